>>> design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the parametric surface grid vertex unit.
// ----------------------------------------------------------------------------
package psg_pkg;

    typedef enum logic [2:0] {
        REG_SHAPE     = 3'd0,
        REG_RADIUS_A  = 3'd1,
        REG_RADIUS_B  = 3'd2,
        REG_U_STEP    = 3'd3,
        REG_V_STEP    = 3'd4,
        REG_GRID_COLS = 3'd5,
        REG_GRID_ROWS = 3'd6
    } t_reg_idx;

    localparam logic [1:0] SHAPE_TUBE   = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE = 2'd1;
    localparam logic [1:0] SHAPE_TORUS  = 2'd2;

    localparam logic [31:0] Q_A1 = 32'd1686629713;
    localparam logic [31:0] Q_B3 = 32'd693598667;
    localparam logic [31:0] Q_B5 = 32'd85569300;
    localparam logic [31:0] Q_B7 = 32'd5026995;
    localparam logic [31:0] Q_B9 = 32'd172272;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  shape;
        logic [15:0] radius_a;
        logic [15:0] radius_b;
        logic [15:0] u_step;
        logic [15:0] v_step;
        logic [6:0]  grid_cols;
        logic [6:0]  grid_rows;
    } t_cfg;

    typedef struct packed {
        logic        oor;
        logic [11:0] index;
        logic        right;
        logic        down;
        logic [1:0]  shape;
        logic [15:0] pu;
        logic [15:0] pv;
        logic [21:0] rv;
    } t_item;

endpackage

>>> design/psg_queue.sv
// ----------------------------------------------------------------------------
// psg_queue
// Short item queue between the front classifier and the back evaluator.
// ----------------------------------------------------------------------------
module psg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psg_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output psg_pkg::t_item o_item
);
    import psg_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/psg_front.sv
// ----------------------------------------------------------------------------
// psg_front
// Input side: range check, vertex index, edge flags and phases of a point.
// ----------------------------------------------------------------------------
module psg_front #(
    parameter int MAX_GRID   = 64,
    parameter int ANGLE_BITS = 16
) (
    input  psg_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [5:0]     i_col,
    input  logic [5:0]     i_row,
    input  logic           i_full,
    output logic           o_push,
    output psg_pkg::t_item o_item
);
    import psg_pkg::*;

    localparam int          KEEP_SHIFT = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
    localparam logic [15:0] PHASE_KEEP = 16'(16'hFFFF << KEEP_SHIFT);
    localparam logic [8:0]  GRID_MAX   = 9'(MAX_GRID);

    logic [6:0]  cols;
    logic [6:0]  rows;
    logic [12:0] index_full;
    logic [21:0] cu_prod;

    always_comb begin
        cols = ({2'b0, i_cfg.grid_cols} > GRID_MAX) ? GRID_MAX[6:0] : i_cfg.grid_cols;
        rows = ({2'b0, i_cfg.grid_rows} > GRID_MAX) ? GRID_MAX[6:0] : i_cfg.grid_rows;
        index_full = 13'({7'b0, i_col}) + 13'(i_row) * 13'(cols);
        cu_prod    = 22'(i_col) * 22'(i_cfg.u_step);

        o_item.oor   = ({1'b0, i_col} >= cols) || ({1'b0, i_row} >= rows);
        o_item.index = index_full[11:0];
        o_item.right = (7'({1'b0, i_col}) + 7'd1) < cols;
        o_item.down  = (7'({1'b0, i_row}) + 7'd1) < rows;
        o_item.shape = i_cfg.shape;
        o_item.pu    = cu_prod[15:0] & PHASE_KEEP;
        o_item.rv    = 22'(i_row) * 22'(i_cfg.v_step);
        o_item.pv    = o_item.rv[15:0] & PHASE_KEEP;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

>>> design/psg_sin.sv
// ----------------------------------------------------------------------------
// psg_sin
// Pipelined Q1.15 sine of a 16-bit phase: quarter-wave fold, odd polynomial.
// ----------------------------------------------------------------------------
module psg_sin (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_phase,
    output logic signed [16:0] o_value
);
    import psg_pkg::*;

    localparam logic [31:0] COEF [1:4] = '{Q_B7, Q_B5, Q_B3, Q_A1};

    logic [14:0] fold;
    logic [15:0] z;
    logic [15:0] r_z   [0:4];
    logic [31:0] r_z2  [0:3];
    logic        r_neg [0:4];
    logic [31:0] r_acc [1:4];
    logic [31:0] acc_in [1:4];
    logic [63:0] prod  [1:4];
    logic [47:0] fin;
    logic [17:0] mag;
    logic [16:0] val;

    assign fold = i_phase[14] ? (15'd16384 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
    assign z    = {fold, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]   <= z;
            r_z2[0]  <= 32'(z) * 32'(z);
            r_neg[0] <= i_phase[15];
        end
    end

    assign acc_in[1] = Q_B9;

    for (genvar k = 1; k <= 4; k++) begin : g_horner
        if (k > 1) begin : g_chain
            assign acc_in[k] = r_acc[k-1];
        end
        assign prod[k] = 64'(acc_in[k]) * 64'(r_z2[k-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= COEF[k] - prod[k][61:30];
                r_z[k]   <= r_z[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (k < 4) begin : g_z2
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z2[k] <= r_z2[k-1];
                end
            end
        end
    end

    always_comb begin
        fin = 48'(r_acc[4]) * 48'(r_z[4]) + 48'd536870912;
        mag = fin[47:30];
        val = (mag > 18'd32767) ? 17'd32767 : {2'b0, mag[14:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value <= r_neg[4] ? -$signed(val) : $signed(val);
        end
    end

endmodule

>>> design/psg_back.sv
// ----------------------------------------------------------------------------
// psg_back
// Evaluator: sine and cosine of both phases, surface products, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module psg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psg_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  psg_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [17:0]    o_pos_x,
    output logic [17:0]    o_pos_y,
    output logic [17:0]    o_pos_z,
    output logic [11:0]    o_vertex_index,
    output logic           o_right_edge,
    output logic           o_down_edge,
    output logic           o_out_of_range
);
    import psg_pkg::*;

    localparam int SIN_LAT = 6;

    function automatic logic signed [51:0] rnd(input logic signed [51:0] v,
                                               input logic [5:0] s);
        logic signed [51:0] half;
        half = 52'sd1 <<< (s - 6'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic [17:0] sat18(input logic signed [51:0] v);
        logic [17:0] r;
        if (v > 52'sd131071) begin
            r = 18'h1FFFF;
        end else if (v < -52'sd131072) begin
            r = 18'h20000;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    logic en;
    logic r_v0;
    t_item r_it0;
    logic  r_mv [1:SIN_LAT];
    t_item r_mi [1:SIN_LAT];

    logic signed [16:0] su, cu, sv, cv;
    logic signed [16:0] a_s;
    logic signed [34:0] b_sh;

    logic               r_v7;
    t_item              r_i7;
    logic signed [33:0] r_as, r_acu, r_asv;
    logic signed [34:0] r_w;
    logic signed [16:0] r_su, r_cu, r_sv, r_cv;
    logic [37:0]        r_rvb;

    logic               r_v8;
    t_item              r_i8;
    logic signed [50:0] r_sx, r_sy;
    logic signed [51:0] r_tx, r_tz;
    logic signed [33:0] r_acu8, r_asv8, r_as8;
    logic [37:0]        r_rvb8;

    logic [38:0] tz_sum;
    logic [17:0] px, py, pz;

    assign en      = !o_valid || !i_stall;
    assign o_q_pop = i_q_valid && en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it0 <= i_q_item;
        end
    end

    psg_sin u_sin_su (.i_clk(i_clk), .i_en(en), .i_phase(r_it0.pu), .o_value(su));
    psg_sin u_sin_cu (.i_clk(i_clk), .i_en(en), .i_phase(r_it0.pu + 16'd16384), .o_value(cu));
    psg_sin u_sin_sv (.i_clk(i_clk), .i_en(en), .i_phase(r_it0.pv), .o_value(sv));
    psg_sin u_sin_cv (.i_clk(i_clk), .i_en(en), .i_phase(r_it0.pv + 16'd16384), .o_value(cv));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mi[1] <= r_it0;
            for (int k = 2; k <= SIN_LAT; k++) begin
                r_mi[k] <= r_mi[k-1];
            end
        end
    end

    assign a_s  = $signed({1'b0, i_cfg.radius_a});
    assign b_sh = $signed({4'b0, i_cfg.radius_b, 15'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i7  <= r_mi[SIN_LAT];
            r_as  <= a_s * su;
            r_acu <= a_s * cu;
            r_asv <= a_s * sv;
            r_w   <= b_sh + 35'(a_s) * 35'(cv);
            r_su  <= su;
            r_cu  <= cu;
            r_sv  <= sv;
            r_cv  <= cv;
            r_rvb <= 38'(r_mi[SIN_LAT].rv) * 38'(i_cfg.radius_b);

            r_i8   <= r_i7;
            r_sx   <= 51'(r_as) * 51'(r_cv);
            r_sy   <= 51'(r_as) * 51'(r_sv);
            r_tx   <= 52'(r_cu) * 52'(r_w);
            r_tz   <= 52'(r_su) * 52'(r_w);
            r_acu8 <= r_acu;
            r_asv8 <= r_asv;
            r_as8  <= r_as;
            r_rvb8 <= r_rvb;
        end
    end

    always_comb begin
        tz_sum = {1'b0, r_rvb8} + 39'd16384;
        px = '0;
        py = '0;
        pz = '0;
        case (r_i8.shape)
            SHAPE_TUBE: begin
                px = sat18(rnd(52'(r_acu8), 6'd15));
                py = sat18(rnd(52'(r_as8), 6'd15));
                pz = sat18($signed({13'b0, tz_sum[38:15]}));
            end
            SHAPE_SPHERE: begin
                px = sat18(rnd(52'(r_sx), 6'd30));
                py = sat18(rnd(52'(r_sy), 6'd30));
                pz = sat18(rnd(52'(r_acu8), 6'd15));
            end
            SHAPE_TORUS: begin
                px = sat18(rnd(r_tx, 6'd30));
                py = sat18(rnd(52'(r_asv8), 6'd15));
                pz = sat18(rnd(r_tz, 6'd30));
            end
            default: begin
                px = '0;
                py = '0;
                pz = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v7    <= 1'b0;
            r_v8    <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 1; k <= SIN_LAT; k++) begin
                r_mv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= i_q_valid;
            r_mv[1] <= r_v0;
            for (int k = 2; k <= SIN_LAT; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            r_v7    <= r_mv[SIN_LAT];
            r_v8    <= r_v7;
            o_valid <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_of_range <= r_i8.oor;
            if (r_i8.oor) begin
                o_pos_x        <= '0;
                o_pos_y        <= '0;
                o_pos_z        <= '0;
                o_vertex_index <= '0;
                o_right_edge   <= 1'b0;
                o_down_edge    <= 1'b0;
            end else begin
                o_pos_x        <= px;
                o_pos_y        <= py;
                o_pos_z        <= pz;
                o_vertex_index <= r_i8.index;
                o_right_edge   <= r_i8.right;
                o_down_edge    <= r_i8.down;
            end
        end
    end

endmodule

>>> design/parametric_surface_grid_vertex_unit.sv
// ----------------------------------------------------------------------------
// parametric_surface_grid_vertex_unit
// Throughput: one item per cycle while the output is not stalled; set by the
// fully pipelined sine and product stages fed from a four-entry queue.
// Reset: synchronous, active low; clears the queue and pipeline valids and
// loads the register defaults.
// ----------------------------------------------------------------------------
module parametric_surface_grid_vertex_unit #(
    parameter int MAX_GRID   = 64,
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_col,
    input  logic [5:0]  i_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [17:0] o_pos_x,
    output logic [17:0] o_pos_y,
    output logic [17:0] o_pos_z,
    output logic [11:0] o_vertex_index,
    output logic        o_right_edge,
    output logic        o_down_edge,
    output logic        o_out_of_range
);
    import psg_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    logic  full;
    logic  q_valid;
    logic  q_pop;
    t_item f_item;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape     <= SHAPE_SPHERE;
            r_cfg.radius_a  <= 16'd256;
            r_cfg.radius_b  <= 16'd512;
            r_cfg.u_step    <= 16'd2114;
            r_cfg.v_step    <= 16'd1057;
            r_cfg.grid_cols <= 7'd32;
            r_cfg.grid_rows <= 7'd32;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SHAPE:     r_cfg.shape     <= i_cfg_data[1:0];
                REG_RADIUS_A:  r_cfg.radius_a  <= i_cfg_data;
                REG_RADIUS_B:  r_cfg.radius_b  <= i_cfg_data;
                REG_U_STEP:    r_cfg.u_step    <= i_cfg_data;
                REG_V_STEP:    r_cfg.v_step    <= i_cfg_data;
                REG_GRID_COLS: r_cfg.grid_cols <= i_cfg_data[6:0];
                REG_GRID_ROWS: r_cfg.grid_rows <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    psg_front #(
        .MAX_GRID   (MAX_GRID),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_col   (i_col),
        .i_row   (i_row),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    psg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    psg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_vertex_index (o_vertex_index),
        .o_right_edge   (o_right_edge),
        .o_down_edge    (o_down_edge),
        .o_out_of_range (o_out_of_range)
    );

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_pos_x == '0 && o_pos_y == '0 &&
        o_pos_z == '0 && o_vertex_index == '0)
        else $error("out-of-range item with nonzero fields");
    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_right_edge || o_down_edge) |-> !o_out_of_range)
        else $error("edge flag on out-of-range item");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_valid && !q_pop ? 1'b1 : q_valid)
        else $error("input stalled with empty queue");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> verif/tb_parametric_surface_grid_vertex_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parametric_surface_grid_vertex_unit
// Self-checking bench: a directed table of grid points under the reset
// settings, then random points over several surface settings (extremes
// included), with random idle bursts on both sides. Every vertex out is
// compared field by field with a table entry or the fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_parametric_surface_grid_vertex_unit;
    import psg_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int GRID_MAX  = 64;
    localparam int DOG_LIMIT = 5000;

    typedef struct packed {
        logic [17:0] x;
        logic [17:0] y;
        logic [17:0] z;
        logic [11:0] idx;
        logic        right;
        logic        down;
        logic        oor;
    } t_vertex;

    typedef struct {
        logic [5:0] col;
        logic [5:0] row;
        bit         typed;
        t_vertex    vtx;
    } t_point;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [5:0]  i_col = '0;
    logic [5:0]  i_row = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [17:0] o_pos_x, o_pos_y, o_pos_z;
    logic [11:0] o_vertex_index;
    logic        o_right_edge, o_down_edge, o_out_of_range;

    t_cfg    cfg;
    t_vertex vertex_q[$];
    bit      cur_typed;
    t_vertex cur_vtx;
    bit      idle_en = 1;
    int      mismatches = 0;
    int      dog = 0;
    int      stall_left = 0;

    parametric_surface_grid_vertex_unit uut (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint quarter_sine(logic [15:0] yv);
        logic [63:0] z, z2, acc, r;
        z   = 64'(yv) << 1;
        z2  = z * z;
        acc = 64'(Q_B9);
        acc = 64'(Q_B7) - ((acc * z2) >> 30);
        acc = 64'(Q_B5) - ((acc * z2) >> 30);
        acc = 64'(Q_B3) - ((acc * z2) >> 30);
        acc = 64'(Q_A1) - ((acc * z2) >> 30);
        r   = (acc * z + (64'd1 << 29)) >> 30;
        return (r > 64'd32767) ? 64'sd32767 : longint'(r);
    endfunction

    function automatic longint phase_sine(logic [15:0] ph);
        logic [13:0] x;
        longint s;
        x = ph[13:0];
        s = quarter_sine(ph[14] ? 16'd16384 - 16'(x) : 16'(x));
        return ph[15] ? -s : s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [17:0] sat18(longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    function automatic t_vertex predict_vertex(t_cfg c, logic [5:0] col, logic [5:0] row);
        t_vertex    v;
        int         cols, rows;
        logic [15:0] pu, pv;
        longint     a, b, su, cu, sv, cv, w, x, y, z;
        v = '0;
        cols = (c.grid_cols > GRID_MAX) ? GRID_MAX : c.grid_cols;
        rows = (c.grid_rows > GRID_MAX) ? GRID_MAX : c.grid_rows;
        if (col >= cols || row >= rows) begin
            v.oor = 1;
            return v;
        end
        a = c.radius_a;
        b = c.radius_b;
        x = 0; y = 0; z = 0;
        pu = 16'(32'(col) * c.u_step);
        pv = 16'(32'(row) * c.v_step);
        su = phase_sine(pu); cu = phase_sine(pu + 16'd16384);
        sv = phase_sine(pv); cv = phase_sine(pv + 16'd16384);
        case (c.shape)
            SHAPE_TUBE: begin
                x = rnd_shift(a * cu, 15);
                y = rnd_shift(a * su, 15);
                z = (longint'(row) * c.v_step * b + (longint'(1) << 14)) >>> 15;
            end
            SHAPE_SPHERE: begin
                x = rnd_shift(a * su * cv, 30);
                y = rnd_shift(a * su * sv, 30);
                z = rnd_shift(a * cu, 15);
            end
            SHAPE_TORUS: begin
                w = b * 32768 + a * cv;
                x = rnd_shift(cu * w, 30);
                y = rnd_shift(a * sv, 15);
                z = rnd_shift(su * w, 30);
            end
            default: ;
        endcase
        v.x = sat18(x);
        v.y = sat18(y);
        v.z = sat18(z);
        v.idx = 12'(32'(col) + 32'(row) * cols);
        v.right = (col + 1 < cols);
        v.down = (row + 1 < rows);
        return v;
    endfunction

    // ---- scoreboard and watchdog
    always @(posedge i_clk) begin
        t_vertex got, want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) dog <= 0;
            else dog <= dog + 1;
            if (dog >= DOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            if (i_in_valid && !o_in_stall)
                vertex_q.insert(vertex_q.size(),
                                cur_typed ? cur_vtx : predict_vertex(cfg, i_col, i_row));
            if (o_out_valid && !i_out_stall) begin
                got = '{o_pos_x, o_pos_y, o_pos_z, o_vertex_index, o_right_edge,
                        o_down_edge, o_out_of_range};
                if (vertex_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item out: %p", got);
                end else begin
                    want = vertex_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("exp %p\n got %p", want, got);
                    end
                end
            end
        end
    end

    // ---- output stall bursts
    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_stall <= 0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 0;
        end
    end

    task automatic send_point(logic [5:0] col, logic [5:0] row, bit typed, t_vertex vtx);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_col <= col;
        i_row <= row;
        cur_typed <= typed;
        cur_vtx <= vtx;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain;
        i_in_valid <= 0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (14) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SHAPE:     cfg.shape = data[1:0];
            REG_RADIUS_A:  cfg.radius_a = data;
            REG_RADIUS_B:  cfg.radius_b = data;
            REG_U_STEP:    cfg.u_step = data;
            REG_V_STEP:    cfg.v_step = data;
            REG_GRID_COLS: cfg.grid_cols = data[6:0];
            REG_GRID_ROWS: cfg.grid_rows = data[6:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(int kind);
        write_reg(REG_SHAPE, (kind == 0) ? 16'd2 : (kind == 1) ? 16'd0 :
                  (kind == 2) ? 16'hFFFF : 16'($urandom_range(0, 2)));
        write_reg(REG_RADIUS_A, (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
        write_reg(REG_RADIUS_B, (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
        write_reg(REG_U_STEP, (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
        write_reg(REG_V_STEP, (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
        write_reg(REG_GRID_COLS, (kind == 0) ? 16'h7F : (kind == 1) ? 16'd1 :
                  (kind == 2) ? 16'd0 : 16'($urandom_range(2, 70)));
        write_reg(REG_GRID_ROWS, (kind == 0) ? 16'd100 : (kind == 1) ? 16'd2 :
                  (kind == 2) ? 16'd64 : 16'($urandom_range(2, 70)));
        if (kind == 2) write_reg(REG_UNUSED, 16'hFFFF);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        t_point dir[$];
        t_vertex oor_v, zero_v;
        int cmax, rmax;
        oor_v = '0;
        oor_v.oor = 1;
        zero_v = '0;
        zero_v.z = 18'd256;
        zero_v.right = 1;
        zero_v.down = 1;
        cfg = '{SHAPE_SPHERE, 16'd256, 16'd512, 16'd2114, 16'd1057, 7'd32, 7'd32};

        dir.insert(dir.size(), t_point'{6'd0, 6'd0, 1, zero_v});
        dir.insert(dir.size(), t_point'{6'd63, 6'd63, 1, oor_v});
        dir.insert(dir.size(), t_point'{6'd32, 6'd0, 1, oor_v});
        dir.insert(dir.size(), t_point'{6'd0, 6'd32, 1, oor_v});
        dir.insert(dir.size(), t_point'{6'd31, 6'd31, 0, '0});
        dir.insert(dir.size(), t_point'{6'd31, 6'd0, 0, '0});
        dir.insert(dir.size(), t_point'{6'd0, 6'd31, 0, '0});
        dir.insert(dir.size(), t_point'{6'd16, 6'd16, 0, '0});
        dir.insert(dir.size(), t_point'{6'd21, 6'd42, 1, oor_v});
        dir.insert(dir.size(), t_point'{6'd30, 6'd1, 0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir[k]) send_point(dir[k].col, dir[k].row, dir[k].typed, dir[k].vtx);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            load_setting(ph < 3 ? ph : 3);
            if (ph == 8) idle_en = 0;
            cmax = (cfg.grid_cols > GRID_MAX) ? GRID_MAX - 1 : int'(cfg.grid_cols) - 1;
            rmax = (cfg.grid_rows > GRID_MAX) ? GRID_MAX - 1 : int'(cfg.grid_rows) - 1;
            repeat (160) begin
                if ($urandom_range(0, 4) != 0 && cmax >= 0 && rmax >= 0)
                    send_point(6'($urandom_range(0, cmax)), 6'($urandom_range(0, rmax)), 0, '0);
                else
                    send_point(6'($urandom), 6'($urandom), 0, '0);
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
